// ----- rtl/core/mhbi_pkg.sv -----
// ----------------------------------------------------------------------------
// mhbi_pkg
// Shared types and codes for the binary max-heap block: beat payloads,
// operation and status codes, compare unit result.
// ----------------------------------------------------------------------------
`default_nettype none

package mhbi_pkg;

   localparam int VAL_W        = 32;
   localparam int SLOT_W       = 5;
   localparam int STREAM_LIMIT = 32;

   // operation codes
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_BUILD  = 2'd1;
   localparam logic [1:0] OP_INSERT = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]              operation;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]       slot;
      logic signed [VAL_W-1:0] entry_value;
      logic                    last;
      logic [1:0]              status;
   } rsp_type;

   typedef struct packed {
      logic                    gt;
      logic signed [VAL_W-1:0] larger;
   } cmp_res_type;

endpackage

`default_nettype wire

// ----- rtl/core/mhbi_ram.sv -----
// ----------------------------------------------------------------------------
// mhbi_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while rd_en is low.
// ----------------------------------------------------------------------------
`default_nettype none

module mhbi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mhbi_cmp.sv -----
// ----------------------------------------------------------------------------
// mhbi_cmp
// Shared signed compare unit: a > b and the larger operand (b on a tie).
// ----------------------------------------------------------------------------
`default_nettype none

module mhbi_cmp (
   input  wire logic signed [mhbi_pkg::VAL_W-1:0] cmp_a,
   input  wire logic signed [mhbi_pkg::VAL_W-1:0] cmp_b,
   output      mhbi_pkg::cmp_res_type             cmp_res
);

   logic a_gt_b;

   assign a_gt_b         = cmp_a > cmp_b;
   assign cmp_res.gt     = a_gt_b;
   assign cmp_res.larger = a_gt_b ? cmp_a : cmp_b;

endmodule

`default_nettype wire

// ----- rtl/core/max_heap_build_insert.sv -----
// ----------------------------------------------------------------------------
// max_heap_build_insert
// Array-stored binary max-heap of signed 32-bit values with append, build
// (heapify) and insert (sift-up), streaming the store after build/insert.
// ----------------------------------------------------------------------------
// Usage: one request beat per operation; req_stall is high while an operation
// runs. Append and rejected/empty requests answer with a single beat held in
// the single-beat register until the output register is free. Insert compares
// one parent per level climbed. Build sifts down each non-leaf, comparing the
// left and then any right child per level, with an extra write at a leaf. Both
// then stream min(count, 32) beats at one beat per cycle unless stalled, after
// a start state that reads slot 0. The pacing is set by the single read port of
// the store RAM, which every compare waits on. The store has no reset; only
// entries below the count are read. The last beat may still sit in the output
// register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_build_insert #(
   parameter int MAX_ENTRIES = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire mhbi_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      mhbi_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CHD_W = IDX_W + 2;     // holds 2*node+2
   localparam int STREAM_MAX = (MAX_ENTRIES < mhbi_pkg::STREAM_LIMIT) ?
                               MAX_ENTRIES : mhbi_pkg::STREAM_LIMIT;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] STREAM_CNT = CNT_W'(STREAM_MAX);

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EMIT     = 4'd1;  // single beat waits for output reg
   localparam logic [3:0] S_UP_TEST  = 4'd2;  // insert: at root or read parent
   localparam logic [3:0] S_UP_CMP   = 4'd3;  // insert: compare parent, move
   localparam logic [3:0] S_SD_NEXT  = 4'd4;  // build: next non-leaf
   localparam logic [3:0] S_SD_NODE  = 4'd5;  // build: latch node value
   localparam logic [3:0] S_SD_CHILD = 4'd6;  // build: read left child
   localparam logic [3:0] S_SD_LEFT  = 4'd7;  // build: compare left
   localparam logic [3:0] S_SD_RIGHT = 4'd8;  // build: compare right
   localparam logic [3:0] S_ST_START = 4'd9;  // stream: read slot 0
   localparam logic [3:0] S_STREAM   = 4'd10; // stream: one beat per cycle unless stalled

   logic [3:0]                        state_ff, state_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic signed [mhbi_pkg::VAL_W-1:0] val_ff, val_in;     // value being moved
   logic [IDX_W-1:0]                  node_ff, node_in;
   logic [IDX_W-1:0]                  best_idx_ff, best_idx_in;
   logic                              best_node_ff, best_node_in;
   logic signed [mhbi_pkg::VAL_W-1:0] best_val_ff, best_val_in;
   logic [IDX_W-1:0]                  i_ff, i_in;
   logic [IDX_W-1:0]                  child_ff, child_in;
   logic [IDX_W-1:0]                  par_ff, par_in;
   logic [IDX_W-1:0]                  ld_idx_ff, ld_idx_in;
   mhbi_pkg::rsp_type                 single_ff, single_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   mhbi_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic                              rsp_load;
   mhbi_pkg::rsp_type                 rsp_next;
   logic                              out_free;

   logic                              ram_wr_en;
   logic [IDX_W-1:0]                  ram_wr_addr;
   logic [mhbi_pkg::VAL_W-1:0]        ram_wr_data;
   logic                              ram_rd_en;
   logic [IDX_W-1:0]                  ram_rd_addr;
   logic [mhbi_pkg::VAL_W-1:0]        ram_rd_raw;
   logic signed [mhbi_pkg::VAL_W-1:0] ram_rd_data;

   logic signed [mhbi_pkg::VAL_W-1:0] cmp_a, cmp_b;
   mhbi_pkg::cmp_res_type             cmp_res;

   logic [CHD_W-1:0]                  left_idx, right_idx, count_ext;
   logic                              left_ok, right_ok;
   logic [IDX_W-1:0]                  parent_idx;
   logic [CNT_W-1:0]                  stream_n, ld_next;
   logic                              ld_last;
   logic [IDX_W-1:0]                  dec_idx;
   logic                              dec_node;

   // store RAM, no reset
   mhbi_ram #(
      .WIDTH (mhbi_pkg::VAL_W),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   assign ram_rd_data = ram_rd_raw;

   // one comparator shared by sift-up and sift-down
   mhbi_cmp u_cmp (
      .cmp_a   (cmp_a),
      .cmp_b   (cmp_b),
      .cmp_res (cmp_res)
   );

   always_comb begin
      cmp_a = ram_rd_data;
      cmp_b = val_ff;
      if (state_ff == S_UP_CMP) begin
         // insert stops when parent >= value, i.e. not (value > parent)
         cmp_a = val_ff;
         cmp_b = ram_rd_data;
      end else if (state_ff == S_SD_RIGHT) begin
         // strict > keeps the left child on a tie
         cmp_b = best_val_ff;
      end
   end

   // child / parent index math
   assign left_idx   = {1'b0, node_ff, 1'b1};
   assign right_idx  = left_idx + CHD_W'(1);
   assign count_ext  = CHD_W'(count_ff);
   assign left_ok    = left_idx < count_ext;
   assign right_ok   = right_idx < count_ext;
   assign parent_idx = (child_ff - IDX_W'(1)) >> 1;

   // stream length and last flag
   assign stream_n = (count_ff > STREAM_CNT) ? STREAM_CNT : count_ff;
   assign ld_next  = CNT_W'(ld_idx_ff) + CNT_W'(1);
   assign ld_last  = ld_next == stream_n;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sift-down decision after the last child compare of a level
   always_comb begin
      if (state_ff == S_SD_RIGHT) begin
         dec_idx  = cmp_res.gt ? IDX_W'(right_idx) : best_idx_ff;
         dec_node = !cmp_res.gt && best_node_ff;
      end else begin
         dec_idx  = cmp_res.gt ? IDX_W'(left_idx) : node_ff;
         dec_node = !cmp_res.gt;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      val_in       = val_ff;
      node_in      = node_ff;
      best_idx_in  = best_idx_ff;
      best_node_in = best_node_ff;
      best_val_in  = best_val_ff;
      i_in         = i_ff;
      child_in     = child_ff;
      par_in       = par_ff;
      ld_idx_in    = ld_idx_ff;
      single_in    = single_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = node_ff;
      ram_wr_data  = val_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = node_ff;
      rsp_load     = 1'b0;
      rsp_next     = single_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.operation)
                  mhbi_pkg::OP_APPEND, mhbi_pkg::OP_INSERT: begin
                     if (count_ff >= FULL_COUNT) begin
                        single_in.slot        = '0;
                        single_in.entry_value = '0;
                        single_in.last        = 1'b1;
                        single_in.status      = mhbi_pkg::STAT_FULL;
                        state_in              = S_EMIT;
                     end else if (req_data.operation == mhbi_pkg::OP_APPEND) begin
                        count_in              = count_ff + CNT_W'(1);
                        ram_wr_en             = 1'b1;
                        ram_wr_addr           = IDX_W'(count_ff);
                        ram_wr_data           = req_data.value;
                        single_in.slot        = mhbi_pkg::SLOT_W'(count_ff);
                        single_in.entry_value = req_data.value;
                        single_in.last        = 1'b1;
                        single_in.status      = mhbi_pkg::STAT_OK;
                        state_in              = S_EMIT;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                        val_in   = req_data.value;
                        child_in = IDX_W'(count_ff);
                        state_in = S_UP_TEST;
                     end
                  end
                  mhbi_pkg::OP_BUILD: begin
                     if (count_ff == '0) begin
                        single_in.slot        = '0;
                        single_in.entry_value = '0;
                        single_in.last        = 1'b1;
                        single_in.status      = mhbi_pkg::STAT_EMPTY;
                        state_in              = S_EMIT;
                     end else begin
                        i_in     = IDX_W'(count_ff >> 1);
                        state_in = S_SD_NEXT;
                     end
                  end
                  default: begin
                     // unused code: dropped, no beat
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_next = single_ff;
               state_in = S_IDLE;
            end
         end
         S_UP_TEST: begin
            if (child_ff == '0) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = '0;
               ram_wr_data = val_ff;
               state_in    = S_ST_START;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = parent_idx;
               par_in      = parent_idx;
               state_in    = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = child_ff;
            if (!cmp_res.gt) begin
               ram_wr_data = val_ff;
               state_in    = S_ST_START;
            end else begin
               // parent moves down, hole moves up
               ram_wr_data = ram_rd_data;
               child_in    = par_ff;
               state_in    = S_UP_TEST;
            end
         end
         S_SD_NEXT: begin
            if (i_ff == '0) begin
               state_in = S_ST_START;
            end else begin
               node_in     = i_ff - IDX_W'(1);
               i_in        = i_ff - IDX_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = i_ff - IDX_W'(1);
               state_in    = S_SD_NODE;
            end
         end
         S_SD_NODE: begin
            val_in   = ram_rd_data;
            state_in = S_SD_CHILD;
         end
         S_SD_CHILD: begin
            if (!left_ok) begin
               // leaf reached: drop the moving value here
               ram_wr_en   = 1'b1;
               ram_wr_data = val_ff;
               state_in    = S_SD_NEXT;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IDX_W'(left_idx);
               state_in    = S_SD_LEFT;
            end
         end
         S_SD_LEFT, S_SD_RIGHT: begin
            if (state_ff == S_SD_LEFT && right_ok) begin
               best_idx_in  = dec_idx;
               best_node_in = dec_node;
               best_val_in  = cmp_res.larger;
               ram_rd_en    = 1'b1;
               ram_rd_addr  = IDX_W'(right_idx);
               state_in     = S_SD_RIGHT;
            end else if (dec_node) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = val_ff;
               state_in    = S_SD_NEXT;
            end else begin
               // larger child moves up, keep sifting at its slot
               ram_wr_en   = 1'b1;
               ram_wr_data = cmp_res.larger;
               node_in     = dec_idx;
               state_in    = S_SD_CHILD;
            end
         end
         S_ST_START: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            ld_idx_in   = '0;
            state_in    = S_STREAM;
         end
         S_STREAM: begin
            // read data holds while rd_en is low, so a stall just waits
            if (out_free) begin
               rsp_load             = 1'b1;
               rsp_next.slot        = mhbi_pkg::SLOT_W'(ld_idx_ff);
               rsp_next.entry_value = ram_rd_data;
               rsp_next.last        = ld_last;
               rsp_next.status      = mhbi_pkg::STAT_OK;
               if (ld_last) begin
                  state_in = S_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = IDX_W'(ld_next);
                  ld_idx_in   = IDX_W'(ld_next);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   assign rsp_data_in  = rsp_load ? rsp_next : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      node_ff      <= node_in;
      best_idx_ff  <= best_idx_in;
      best_node_ff <= best_node_in;
      best_val_ff  <= best_val_in;
      i_ff         <= i_in;
      child_ff     <= child_in;
      par_ff       <= par_in;
      ld_idx_ff    <= ld_idx_in;
      single_ff    <= single_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // writes only land below the (updated) entry count
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (CNT_W'(ram_wr_addr) < count_in))
      else $error("store write beyond entry count");

   // the sequencer never reads and writes the store in one cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("store read and write in the same cycle");

   // a non-last beat in the output register means the stream is still running
   a_stream_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.last) |-> (state_ff == S_STREAM))
      else $error("non-last beat outside a stream");

   // entry count moves only right after an accepted request beat
   a_count_on_accept: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         $past(req_valid && !req_stall))
      else $error("entry count changed without a request");

endmodule

`default_nettype wire

// ----- tb/sv/max_heap_build_insert_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_build_insert_test
// Self-checking bench for the array-stored max-heap. A class keeps its own
// copy of the store and entry count and works out the beats that each
// accepted request must produce. Every result beat is matched against them.
// Stimulus is a short directed sequence, then random appends, inserts and
// builds until the store fills, then rejects and rebuilds. Both channels
// idle in random bursts.
// ----------------------------------------------------------------------------

module max_heap_build_insert_test;
   import mhbi_pkg::*;

   localparam int HEAP_DEPTH   = 32;
   localparam int RANDOM_ITEMS = 400;
   localparam int TAIL_ITEMS   = 40;     // last stretch runs with no idling
   localparam int DRAIN_CYCLES = 16;     // output register plus some slack
   // code 3 is not an operation; the block must drop it silently
   localparam logic [1:0] OP_DROPPED = 2'd3;

   // -------------------------------------------------------------------------
   // Heap mirror: private copy of the store, plus the beats still owed.
   // -------------------------------------------------------------------------
   class heap_mirror;
      logic signed [VAL_W-1:0] store [HEAP_DEPTH];
      int unsigned             fill;
      rsp_type                 beats_due [$];
      int                      errors;
      int                      beats_checked;
      int                      full_seen;
      int                      empty_seen;
      int                      op_seen [4];

      function void owe_beat(int unsigned slot, logic signed [VAL_W-1:0] val,
                             logic last, logic [1:0] status);
         rsp_type b;
         b.slot        = slot[SLOT_W-1:0];
         b.entry_value = val;
         b.last        = last;
         b.status      = status;
         beats_due.push_back(b);
      endfunction

      // build and insert both dump the store in index order
      function void owe_store_dump();
         int unsigned n;
         n = (fill < STREAM_LIMIT) ? fill : STREAM_LIMIT;
         for (int unsigned i = 0; i < n; i++)
            owe_beat(i, store[i], (i + 1 == n), STAT_OK);
      endfunction

      function void take_request(req_type r);
         logic signed [VAL_W-1:0] v;
         logic signed [VAL_W-1:0] swap;
         int unsigned child, parent, node, pick, lc, rc;
         bit sinking;
         v = r.value;
         op_seen[r.operation]++;
         case (r.operation)
            OP_APPEND, OP_INSERT: begin
               if (fill >= HEAP_DEPTH) begin
                  // rejected, store untouched
                  owe_beat(0, '0, 1'b1, STAT_FULL);
               end else if (r.operation == OP_APPEND) begin
                  store[fill] = v;
                  owe_beat(fill, v, 1'b1, STAT_OK);
                  fill++;
               end else begin
                  // sift-up: move smaller parents down, stop on parent >= v
                  child = fill;
                  fill++;
                  while (child > 0) begin
                     parent = (child - 1) / 2;
                     if (store[parent] >= v) break;
                     store[child] = store[parent];
                     child = parent;
                  end
                  store[child] = v;
                  owe_store_dump();
               end
            end
            OP_BUILD: begin
               if (fill == 0) begin
                  owe_beat(0, '0, 1'b1, STAT_EMPTY);
               end else begin
                  // sift-down each non-leaf, last one first; strict compare
                  // so the left child wins a tie
                  for (int unsigned i = fill / 2; i > 0; i--) begin
                     node    = i - 1;
                     sinking = 1'b1;
                     while (sinking) begin
                        pick = node;
                        lc   = 2 * node + 1;
                        rc   = lc + 1;
                        if (lc < fill && store[lc] > store[pick]) pick = lc;
                        if (rc < fill && store[rc] > store[pick]) pick = rc;
                        if (pick == node) begin
                           sinking = 1'b0;
                        end else begin
                           swap        = store[node];
                           store[node] = store[pick];
                           store[pick] = swap;
                           node        = pick;
                        end
                     end
                  end
                  owe_store_dump();
               end
            end
            default: ;  // dropped code: no beat, no state change
         endcase
      endfunction

      function void match_beat(rsp_type got);
         rsp_type want;
         if (beats_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat: expected none, actual slot=%0d %s",
                     $time, got.slot, "(see value, last, status below)");
            $display("%0t:    value=%0d last=%0b status=%0d",
                     $time, got.entry_value, got.last, got.status);
            return;
         end
         want = beats_due.pop_front();
         beats_checked++;
         if (want.status == STAT_FULL) full_seen++;
         if (want.status == STAT_EMPTY) empty_seen++;
         if (got.slot !== want.slot) begin
            errors++;
            $display("%0t: slot mismatch: expected %0d, actual %0d",
                     $time, want.slot, got.slot);
         end
         if (got.entry_value !== want.entry_value) begin
            errors++;
            $display("%0t: entry_value mismatch at slot %0d: expected %0d, actual %0d",
                     $time, want.slot, want.entry_value, got.entry_value);
         end
         if (got.last !== want.last) begin
            errors++;
            $display("%0t: last mismatch at slot %0d: expected %0b, actual %0b",
                     $time, want.slot, want.last, got.last);
         end
         if (got.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, DUT
   // -------------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   wire     req_stall;
   wire     rsp_valid;
   rsp_type rsp_data;

   bit         quiet_tail = 1'b0;   // set for the final stretch: no idling
   int         hold_left  = 0;      // receiver stall burst remaining
   int         calm_left  = 0;      // receiver no-stall stretch remaining
   heap_mirror mirror     = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   max_heap_build_insert #(
      .MAX_ENTRIES (HEAP_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // -------------------------------------------------------------------------
   // Request side. One beat per call; an optional idle burst goes first.
   // Valid stays high between back-to-back beats.
   // -------------------------------------------------------------------------
   task automatic issue(input logic [1:0] op, input logic signed [VAL_W-1:0] v);
      req_type beat;
      beat.operation = op;
      beat.value     = v;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      // accepted on the first edge that sees stall low
      do @(posedge clock); while (req_stall);
      mirror.take_request(beat);
   endtask

   // mix of extremes, a narrow band (forces ties) and full-range values
   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3, 4: return $signed($urandom_range(0, 6)) - 3;
         default: return $urandom;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Result side: stall bursts of random length, with calm stretches between.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (quiet_tail) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_left == 0 && calm_left == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2: hold_left = $urandom_range(1, 18);
               3:       calm_left = $urandom_range(20, 80);
               default: ;
            endcase
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (calm_left > 0) calm_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) mirror.match_beat(rsp_data);
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int          counted;
      int unsigned roll;
      logic [1:0]  op;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty build, dropped code, extremes, sift-up to the root,
      // sift-up stopping on an equal parent, equal children in a build
      issue(OP_BUILD,   $urandom);           // empty store
      issue(OP_DROPPED, 32'sh7FFF_FFFF);     // ignored
      issue(OP_APPEND,  -32'sd1);
      issue(OP_APPEND,  32'sh8000_0000);
      issue(OP_APPEND,  32'sd0);
      issue(OP_BUILD,   32'sh8000_0000);
      issue(OP_INSERT,  32'sd50);            // climbs to the root
      issue(OP_INSERT,  32'sd50);            // climbs one level, stops on the equal root
      issue(OP_APPEND,  32'sd9);
      issue(OP_APPEND,  32'sd9);             // equal siblings under one node
      issue(OP_APPEND,  -32'sd7);
      issue(OP_APPEND,  32'sd60);
      issue(OP_BUILD,   -32'sd1);
      issue(OP_INSERT,  32'sh7FFF_FFFF);
      issue(OP_INSERT,  32'sh8000_0000);
      issue(OP_DROPPED, 32'sh8000_0000);
      issue(OP_INSERT,  32'sh7FFF_FFFF);     // equal to root
      issue(OP_APPEND,  32'sh5555_5555);
      issue(OP_APPEND,  32'shAAAA_AAAA);
      issue(OP_BUILD,   32'sd0);

      // random: fills the store with mixed builds, then exercises rejects
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         quiet_tail <= (counted >= RANDOM_ITEMS - TAIL_ITEMS);
         roll = $urandom_range(0, 19);
         op   = (roll < 9)  ? OP_APPEND :
                (roll < 14) ? OP_INSERT :
                (roll < 18) ? OP_BUILD  : OP_DROPPED;
         issue(op, pick_value());
         if (op != OP_DROPPED) counted++;
      end
      req_valid <= 1'b0;

      while (mirror.beats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d appends, %0d inserts, %0d builds, %0d dropped codes.",
               mirror.op_seen[OP_APPEND], mirror.op_seen[OP_INSERT],
               mirror.op_seen[OP_BUILD], mirror.op_seen[OP_DROPPED]);
      $display("Matched %0d result beats: %0d full rejects, %0d empty builds, final size %0d.",
               mirror.beats_checked, mirror.full_seen, mirror.empty_seen, mirror.fill);
      if (mirror.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("Timeout with %0d beats still due.", mirror.beats_due.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- max_heap_build_insert.f -----
rtl/core/mhbi_pkg.sv
rtl/core/mhbi_ram.sv
rtl/core/mhbi_cmp.sv
rtl/core/max_heap_build_insert.sv
tb/sv/max_heap_build_insert_test.sv
